// ----- design/wlra_pkg.sv -----
// Shared constants, types and a helper function for the weighted linear
// regression accumulator. No dependencies.
package wlra_pkg;

    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int WEIGHT_WIDTH_DEF = 8;
    localparam int FRAC_BITS_DEF    = 16;

    // Working width of the shared arithmetic unit (covers Dx*Dy and N<<F).
    localparam int BIG_W = 200;

    localparam logic [1:0] FUNC_ADD    = 2'd0;
    localparam logic [1:0] FUNC_REMOVE = 2'd1;
    localparam logic [1:0] FUNC_CLEAR  = 2'd2;
    localparam logic [1:0] FUNC_QUERY  = 2'd3;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_ZERO_W  = 2'd1;
    localparam logic [1:0] STAT_ZERO_DX = 2'd2;
    localparam logic [1:0] STAT_ZERO_DY = 2'd3;

    localparam logic [1:0] OP_MUL  = 2'd0;
    localparam logic [1:0] OP_DIV  = 2'd1;
    localparam logic [1:0] OP_SQRT = 2'd2;

    typedef logic [BIG_W-1:0] big_t;

    // Saturate a two's complement value to a signed field of w bits.
    function automatic logic [63:0] sat_field(input big_t v, input int unsigned w);
        big_t max_v;
        big_t min_v;
        logic [63:0] r;
        max_v = (big_t'(1) << (w - 1)) - big_t'(1);
        min_v = ~max_v;
        if ($signed(v) > $signed(max_v))
            r = max_v[63:0];
        else if ($signed(v) < $signed(min_v))
            r = min_v[63:0];
        else
            r = v[63:0];
        return r;
    endfunction

endpackage

// ----- design/weighted_linear_regression_accumulator_unit.sv -----
// Weighted least-squares regression accumulator: running sums and query sequencer.
// Depends on wlra_pkg.
//
// Add and remove beats register weight*sample when taken, then form the
// square and cross products and update the sums; clear zeroes them when taken.
// A query runs a fixed program of products, truncating divisions and one
// integer square root on a single 200-bit shift/add/subtract unit: a
// multiply takes one multiplier bit per cycle and stops when the multiplier
// runs out, a division is restoring and the root is found digit by digit,
// and each operation passes the setup, run, finish and writeback states.
// A query stops after the means when the x spread is zero, after the
// intercept when only the y spread is zero, and skips the program when the
// weight sum is zero. The input is not ready while a beat is in work; a
// finished result waits in an output register while the next beat is taken.
module weighted_linear_regression_accumulator_unit #(
    parameter int SAMPLE_WIDTH = wlra_pkg::SAMPLE_WIDTH_DEF,
    parameter int WEIGHT_WIDTH = wlra_pkg::WEIGHT_WIDTH_DEF,
    parameter int FRAC_BITS    = wlra_pkg::FRAC_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [1:0]                     func,
    input  logic signed [SAMPLE_WIDTH-1:0] x_value,
    input  logic signed [SAMPLE_WIDTH-1:0] y_value,
    input  logic [WEIGHT_WIDTH-1:0]        weight,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [31:0]             weight_total,
    output logic signed [31:0]             mean_x,
    output logic signed [31:0]             mean_y,
    output logic signed [63:0]             centered_sq_x,
    output logic signed [63:0]             centered_sq_y,
    output logic signed [63:0]             centered_xy,
    output logic signed [47:0]             slope,
    output logic signed [47:0]             intercept,
    output logic signed [17:0]             correlation,
    output logic [1:0]                     status
);

    localparam int BW    = wlra_pkg::BIG_W;
    localparam int PW    = SAMPLE_WIDTH + WEIGHT_WIDTH + 1;
    localparam int PP    = PW + SAMPLE_WIDTH;
    localparam int CNT_W = $clog2(BW);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ACC   = 3'd1;
    localparam logic [2:0] ST_START = 3'd2;
    localparam logic [2:0] ST_RUN   = 3'd3;
    localparam logic [2:0] ST_FIN   = 3'd4;
    localparam logic [2:0] ST_WB    = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;

    localparam logic [4:0] S_SQX   = 5'd0;
    localparam logic [4:0] S_CXX   = 5'd1;
    localparam logic [4:0] S_DX    = 5'd2;
    localparam logic [4:0] S_SQY   = 5'd3;
    localparam logic [4:0] S_CYY   = 5'd4;
    localparam logic [4:0] S_DY    = 5'd5;
    localparam logic [4:0] S_SQXY  = 5'd6;
    localparam logic [4:0] S_CXY   = 5'd7;
    localparam logic [4:0] S_N     = 5'd8;
    localparam logic [4:0] S_MX    = 5'd9;
    localparam logic [4:0] S_MY    = 5'd10;
    localparam logic [4:0] S_SLOPE = 5'd11;
    localparam logic [4:0] S_SX    = 5'd12;
    localparam logic [4:0] S_ICPT  = 5'd13;
    localparam logic [4:0] S_PROD  = 5'd14;
    localparam logic [4:0] S_ROOT  = 5'd15;
    localparam logic [4:0] S_CORR  = 5'd16;

    // control
    logic [2:0]       state_reg;
    logic [4:0]       step_reg;
    logic [1:0]       op_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             neg_reg;
    logic             sub_reg;
    logic             out_valid_reg;

    // accumulators
    logic [31:0] acc_weight_reg;
    logic [47:0] acc_x_reg;
    logic [47:0] acc_y_reg;
    logic [63:0] acc_xx_reg;
    logic [63:0] acc_yy_reg;
    logic [63:0] acc_xy_reg;

    // add pipeline
    logic signed [PW-1:0]           wx_reg;
    logic signed [PW-1:0]           wy_reg;
    logic signed [SAMPLE_WIDTH-1:0] xs_reg;
    logic signed [SAMPLE_WIDTH-1:0] ys_reg;
    logic [WEIGHT_WIDTH-1:0]        w_in_reg;
    logic signed [PW-1:0]           wx_c;
    logic signed [PW-1:0]           wy_c;
    logic signed [PP-1:0]           sxx_c;
    logic signed [PP-1:0]           syy_c;
    logic signed [PP-1:0]           sxy_c;

    // shared unit
    wlra_pkg::big_t u_a_reg;
    wlra_pkg::big_t u_b_reg;
    wlra_pkg::big_t u_r_reg;
    wlra_pkg::big_t u_q_reg;
    wlra_pkg::big_t t_sq_reg;
    wlra_pkg::big_t t_dx_reg;
    wlra_pkg::big_t t_dy_reg;
    wlra_pkg::big_t t_n_reg;

    // working results and output register
    logic [31:0] wk_mx_reg;
    logic [31:0] wk_my_reg;
    logic [63:0] wk_cxx_reg;
    logic [63:0] wk_cyy_reg;
    logic [63:0] wk_cxy_reg;
    logic [47:0] wk_slope_reg;
    logic [47:0] wk_icpt_reg;
    logic [17:0] wk_corr_reg;
    logic [1:0]  wk_status_reg;
    logic [31:0] weight_total_reg;
    logic [31:0] mean_x_reg;
    logic [31:0] mean_y_reg;
    logic [63:0] cxx_reg;
    logic [63:0] cyy_reg;
    logic [63:0] cxy_reg;
    logic [47:0] slope_reg;
    logic [47:0] icpt_reg;
    logic [17:0] corr_reg;
    logic [1:0]  status_reg;

    logic             in_fire;
    logic             out_free;
    logic             load_out;
    wlra_pkg::big_t   big_w;
    wlra_pkg::big_t   big_x;
    wlra_pkg::big_t   big_y;
    wlra_pkg::big_t   big_xx;
    wlra_pkg::big_t   big_yy;
    wlra_pkg::big_t   big_xy;
    wlra_pkg::big_t   big_slope;
    logic [1:0]       step_op;
    wlra_pkg::big_t   step_a;
    wlra_pkg::big_t   step_b;
    wlra_pkg::big_t   abs_a;
    wlra_pkg::big_t   abs_b;
    wlra_pkg::big_t   div_rs;
    wlra_pkg::big_t   sq_rs;
    wlra_pkg::big_t   sq_trial;
    wlra_pkg::big_t   add_x;
    wlra_pkg::big_t   add_y;
    logic             add_sub;
    logic [BW:0]      add_sum;
    logic             add_ge;
    wlra_pkg::big_t   fin_mag;
    logic             dx_bad;
    logic             dy_bad;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign load_out = (state_reg == ST_OUT) && out_free;

    assign wx_c  = PW'(x_value) * PW'($signed({1'b0, weight}));
    assign wy_c  = PW'(y_value) * PW'($signed({1'b0, weight}));
    assign sxx_c = PP'(wx_reg) * PP'(xs_reg);
    assign syy_c = PP'(wy_reg) * PP'(ys_reg);
    assign sxy_c = PP'(wx_reg) * PP'(ys_reg);

    assign big_w     = {{(BW-32){acc_weight_reg[31]}}, acc_weight_reg};
    assign big_x     = {{(BW-48){acc_x_reg[47]}}, acc_x_reg};
    assign big_y     = {{(BW-48){acc_y_reg[47]}}, acc_y_reg};
    assign big_xx    = {{(BW-64){acc_xx_reg[63]}}, acc_xx_reg};
    assign big_yy    = {{(BW-64){acc_yy_reg[63]}}, acc_yy_reg};
    assign big_xy    = {{(BW-64){acc_xy_reg[63]}}, acc_xy_reg};
    assign big_slope = {{(BW-48){wk_slope_reg[47]}}, wk_slope_reg};

    assign dx_bad = t_dx_reg[BW-1] || (t_dx_reg == '0);
    assign dy_bad = t_dy_reg[BW-1] || (t_dy_reg == '0);

    // operation program
    always_comb
    begin
        step_op = wlra_pkg::OP_MUL;
        step_a  = big_x;
        step_b  = big_x;
        case (step_reg)
            S_SQX:   begin step_op = wlra_pkg::OP_MUL; step_a = big_x; step_b = big_x; end
            S_CXX:   begin step_op = wlra_pkg::OP_DIV; step_a = t_sq_reg; step_b = big_w; end
            S_DX:    begin step_op = wlra_pkg::OP_MUL; step_a = big_w; step_b = big_xx; end
            S_SQY:   begin step_op = wlra_pkg::OP_MUL; step_a = big_y; step_b = big_y; end
            S_CYY:   begin step_op = wlra_pkg::OP_DIV; step_a = t_sq_reg; step_b = big_w; end
            S_DY:    begin step_op = wlra_pkg::OP_MUL; step_a = big_w; step_b = big_yy; end
            S_SQXY:  begin step_op = wlra_pkg::OP_MUL; step_a = big_x; step_b = big_y; end
            S_CXY:   begin step_op = wlra_pkg::OP_DIV; step_a = t_sq_reg; step_b = big_w; end
            S_N:     begin step_op = wlra_pkg::OP_MUL; step_a = big_w; step_b = big_xy; end
            S_MX:
            begin
                step_op = wlra_pkg::OP_DIV;
                step_a  = big_x << FRAC_BITS;
                step_b  = big_w;
            end
            S_MY:
            begin
                step_op = wlra_pkg::OP_DIV;
                step_a  = big_y << FRAC_BITS;
                step_b  = big_w;
            end
            S_SLOPE:
            begin
                step_op = wlra_pkg::OP_DIV;
                step_a  = t_n_reg << FRAC_BITS;
                step_b  = t_dx_reg;
            end
            S_SX:    begin step_op = wlra_pkg::OP_MUL; step_a = big_slope; step_b = big_x; end
            S_ICPT:  begin step_op = wlra_pkg::OP_DIV; step_a = t_sq_reg; step_b = big_w; end
            S_PROD:  begin step_op = wlra_pkg::OP_MUL; step_a = t_dx_reg; step_b = t_dy_reg; end
            S_ROOT:  begin step_op = wlra_pkg::OP_SQRT; step_a = t_sq_reg; step_b = t_sq_reg; end
            S_CORR:
            begin
                step_op = wlra_pkg::OP_DIV;
                step_a  = t_n_reg << FRAC_BITS;
                step_b  = t_sq_reg;
            end
            default:
            begin
                step_op = wlra_pkg::OP_MUL;
                step_a  = big_x;
                step_b  = big_x;
            end
        endcase
    end

    assign abs_a = step_a[BW-1] ? (~step_a + 1'b1) : step_a;
    assign abs_b = step_b[BW-1] ? (~step_b + 1'b1) : step_b;

    // shared adder/subtractor
    assign div_rs   = {u_r_reg[BW-2:0], u_a_reg[BW-1]};
    assign sq_rs    = {u_r_reg[BW-3:0], u_a_reg[BW-1 -: 2]};
    assign sq_trial = {u_q_reg[BW-3:0], 2'b01};

    always_comb
    begin
        case (op_reg)
            wlra_pkg::OP_MUL:  begin add_x = u_r_reg; add_y = u_a_reg; add_sub = 1'b0; end
            wlra_pkg::OP_DIV:  begin add_x = div_rs; add_y = u_b_reg; add_sub = 1'b1; end
            wlra_pkg::OP_SQRT: begin add_x = sq_rs; add_y = sq_trial; add_sub = 1'b1; end
            default:           begin add_x = u_r_reg; add_y = u_a_reg; add_sub = 1'b0; end
        endcase
    end

    assign add_sum = {1'b0, add_x} + {1'b0, (add_sub ? ~add_y : add_y)} + (BW+1)'(add_sub);
    assign add_ge  = add_sum[BW];
    assign fin_mag = (op_reg == wlra_pkg::OP_MUL) ? u_r_reg : u_q_reg;

    // sequencer and accumulators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            step_reg       <= S_SQX;
            op_reg         <= wlra_pkg::OP_MUL;
            cnt_reg        <= '0;
            neg_reg        <= 1'b0;
            sub_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
            acc_weight_reg <= '0;
            acc_x_reg      <= '0;
            acc_y_reg      <= '0;
            acc_xx_reg     <= '0;
            acc_yy_reg     <= '0;
            acc_xy_reg     <= '0;
        end
        else
        begin
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        case (func)
                            wlra_pkg::FUNC_ADD, wlra_pkg::FUNC_REMOVE:
                            begin
                                sub_reg   <= (func == wlra_pkg::FUNC_REMOVE);
                                state_reg <= ST_ACC;
                            end
                            wlra_pkg::FUNC_CLEAR:
                            begin
                                acc_weight_reg <= '0;
                                acc_x_reg      <= '0;
                                acc_y_reg      <= '0;
                                acc_xx_reg     <= '0;
                                acc_yy_reg     <= '0;
                                acc_xy_reg     <= '0;
                            end
                            default:
                            begin
                                step_reg  <= S_SQX;
                                state_reg <= (acc_weight_reg == '0) ? ST_OUT : ST_START;
                            end
                        endcase
                    end
                end
                ST_ACC:
                begin
                    if (sub_reg)
                    begin
                        acc_weight_reg <= acc_weight_reg - 32'(w_in_reg);
                        acc_x_reg      <= acc_x_reg - 48'(wx_reg);
                        acc_y_reg      <= acc_y_reg - 48'(wy_reg);
                        acc_xx_reg     <= acc_xx_reg - 64'(sxx_c);
                        acc_yy_reg     <= acc_yy_reg - 64'(syy_c);
                        acc_xy_reg     <= acc_xy_reg - 64'(sxy_c);
                    end
                    else
                    begin
                        acc_weight_reg <= acc_weight_reg + 32'(w_in_reg);
                        acc_x_reg      <= acc_x_reg + 48'(wx_reg);
                        acc_y_reg      <= acc_y_reg + 48'(wy_reg);
                        acc_xx_reg     <= acc_xx_reg + 64'(sxx_c);
                        acc_yy_reg     <= acc_yy_reg + 64'(syy_c);
                        acc_xy_reg     <= acc_xy_reg + 64'(sxy_c);
                    end
                    state_reg <= ST_IDLE;
                end
                ST_START:
                begin
                    op_reg    <= step_op;
                    neg_reg   <= (step_op != wlra_pkg::OP_SQRT) && (step_a[BW-1] ^ step_b[BW-1]);
                    cnt_reg   <= '0;
                    state_reg <= ST_RUN;
                end
                ST_RUN:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    case (op_reg)
                        wlra_pkg::OP_MUL:
                        begin
                            if (u_b_reg == '0)
                                state_reg <= ST_FIN;
                        end
                        wlra_pkg::OP_DIV:
                        begin
                            if (cnt_reg == CNT_W'(BW - 1))
                                state_reg <= ST_FIN;
                        end
                        default:
                        begin
                            if (cnt_reg == CNT_W'(BW / 2 - 1))
                                state_reg <= ST_FIN;
                        end
                    endcase
                end
                ST_FIN:
                begin
                    state_reg <= ST_WB;
                end
                ST_WB:
                begin
                    if ((step_reg == S_MY && dx_bad) || (step_reg == S_ICPT && dy_bad)
                        || step_reg == S_CORR)
                        state_reg <= ST_OUT;
                    else
                    begin
                        step_reg  <= step_reg + 1'b1;
                        state_reg <= ST_START;
                    end
                end
                ST_OUT:
                begin
                    if (out_free)
                        state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            wx_reg   <= wx_c;
            wy_reg   <= wy_c;
            xs_reg   <= x_value;
            ys_reg   <= y_value;
            w_in_reg <= weight;
        end

        if (in_fire && func == wlra_pkg::FUNC_QUERY)
        begin
            wk_mx_reg     <= '0;
            wk_my_reg     <= '0;
            wk_cxx_reg    <= '0;
            wk_cyy_reg    <= '0;
            wk_cxy_reg    <= '0;
            wk_slope_reg  <= '0;
            wk_icpt_reg   <= '0;
            wk_corr_reg   <= '0;
            wk_status_reg <= (acc_weight_reg == '0) ? wlra_pkg::STAT_ZERO_W : wlra_pkg::STAT_OK;
        end

        case (state_reg)
            ST_START:
            begin
                u_a_reg <= abs_a;
                u_b_reg <= abs_b;
                u_r_reg <= '0;
                u_q_reg <= '0;
            end
            ST_RUN:
            begin
                case (op_reg)
                    wlra_pkg::OP_MUL:
                    begin
                        if (u_b_reg[0])
                            u_r_reg <= add_sum[BW-1:0];
                        u_a_reg <= u_a_reg << 1;
                        u_b_reg <= u_b_reg >> 1;
                    end
                    wlra_pkg::OP_DIV:
                    begin
                        u_r_reg <= add_ge ? add_sum[BW-1:0] : div_rs;
                        u_q_reg <= {u_q_reg[BW-2:0], add_ge};
                        u_a_reg <= u_a_reg << 1;
                    end
                    default:
                    begin
                        u_r_reg <= add_ge ? add_sum[BW-1:0] : sq_rs;
                        u_q_reg <= {u_q_reg[BW-2:0], add_ge};
                        u_a_reg <= u_a_reg << 2;
                    end
                endcase
            end
            ST_FIN:
            begin
                u_r_reg <= neg_reg ? (~fin_mag + 1'b1) : fin_mag;
            end
            ST_WB:
            begin
                case (step_reg)
                    S_SQX, S_SQY, S_SQXY, S_PROD, S_ROOT: t_sq_reg <= u_r_reg;
                    S_CXX:   wk_cxx_reg <= acc_xx_reg - u_r_reg[63:0];
                    S_DX:    t_dx_reg <= u_r_reg - t_sq_reg;
                    S_CYY:   wk_cyy_reg <= acc_yy_reg - u_r_reg[63:0];
                    S_DY:    t_dy_reg <= u_r_reg - t_sq_reg;
                    S_CXY:   wk_cxy_reg <= acc_xy_reg - u_r_reg[63:0];
                    S_N:     t_n_reg <= u_r_reg - t_sq_reg;
                    S_MX:    wk_mx_reg <= 32'(wlra_pkg::sat_field(u_r_reg, 32));
                    S_MY:
                    begin
                        wk_my_reg <= 32'(wlra_pkg::sat_field(u_r_reg, 32));
                        if (dx_bad)
                            wk_status_reg <= wlra_pkg::STAT_ZERO_DX;
                    end
                    S_SLOPE: wk_slope_reg <= 48'(wlra_pkg::sat_field(u_r_reg, 48));
                    S_SX:    t_sq_reg <= (big_y << FRAC_BITS) - u_r_reg;
                    S_ICPT:
                    begin
                        wk_icpt_reg <= 48'(wlra_pkg::sat_field(u_r_reg, 48));
                        if (dy_bad)
                            wk_status_reg <= wlra_pkg::STAT_ZERO_DY;
                    end
                    S_CORR:  wk_corr_reg <= 18'(wlra_pkg::sat_field(u_r_reg, 18));
                    default: t_sq_reg <= t_sq_reg;
                endcase
            end
            default:
            begin
                u_r_reg <= u_r_reg;
            end
        endcase

        if (load_out)
        begin
            weight_total_reg <= acc_weight_reg;
            mean_x_reg       <= wk_mx_reg;
            mean_y_reg       <= wk_my_reg;
            cxx_reg          <= wk_cxx_reg;
            cyy_reg          <= wk_cyy_reg;
            cxy_reg          <= wk_cxy_reg;
            slope_reg        <= wk_slope_reg;
            icpt_reg         <= wk_icpt_reg;
            corr_reg         <= wk_corr_reg;
            status_reg       <= wk_status_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign weight_total  = weight_total_reg;
    assign mean_x        = mean_x_reg;
    assign mean_y        = mean_y_reg;
    assign centered_sq_x = cxx_reg;
    assign centered_sq_y = cyy_reg;
    assign centered_xy   = cxy_reg;
    assign slope         = slope_reg;
    assign intercept     = icpt_reg;
    assign correlation   = corr_reg;
    assign status        = status_reg;

    // divisor is never zero: weight, x spread and y spread are checked first
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_START && step_op == wlra_pkg::OP_DIV) |-> (step_b != '0))
        else $error("division started with zero divisor");

    a_zero_weight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && func == wlra_pkg::FUNC_QUERY && acc_weight_reg == '0)
        |=> (state_reg == ST_OUT))
        else $error("zero weight query did not skip the program");

    a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN && op_reg == wlra_pkg::OP_DIV) |-> (cnt_reg <= CNT_W'(BW - 1)))
        else $error("division ran past its width");

    a_zero_w_result: assert property (@(posedge clk) disable iff (!rst_n)
        ($rose(out_valid_reg) && status_reg == wlra_pkg::STAT_ZERO_W)
        |-> (mean_x_reg == '0 && slope_reg == '0 && corr_reg == '0))
        else $error("zero weight result carries nonzero fields");

endmodule

// ----- dv/wlra_scoreboard.sv -----
// Checker for the weighted regression accumulator: tracks the running sums from
// accepted input beats, predicts each query result and compares result beats.
// Depends on wlra_pkg.
`timescale 1ns / 1ps

module wlra_scoreboard (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [1:0]         func,
    input  logic signed [15:0] x_value,
    input  logic signed [15:0] y_value,
    input  logic [7:0]         weight,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic signed [31:0] weight_total,
    input  logic signed [31:0] mean_x,
    input  logic signed [31:0] mean_y,
    input  logic signed [63:0] centered_sq_x,
    input  logic signed [63:0] centered_sq_y,
    input  logic signed [63:0] centered_xy,
    input  logic signed [47:0] slope,
    input  logic signed [47:0] intercept,
    input  logic signed [17:0] correlation,
    input  logic [1:0]         status,
    output int                 fail_count,
    output int                 results_checked,
    output int                 results_pending
);

    typedef logic signed [255:0] wide_t;

    typedef struct {
        logic [31:0] wt;
        logic [31:0] mx;
        logic [31:0] my;
        logic [63:0] cxx;
        logic [63:0] cyy;
        logic [63:0] cxy;
        logic [47:0] slp;
        logic [47:0] icp;
        logic [17:0] cor;
        logic [1:0]  st;
    } fit_result_t;

    logic signed [31:0] sum_w;
    logic signed [47:0] sum_x;
    logic signed [47:0] sum_y;
    logic signed [63:0] sum_xx;
    logic signed [63:0] sum_yy;
    logic signed [63:0] sum_xy;

    fit_result_t fit_queue[$];

    function automatic wide_t clamp_signed(input wide_t v, input int w);
        wide_t hi;
        wide_t lo;
        hi = (wide_t'(1) <<< (w - 1)) - wide_t'(1);
        lo = -hi - wide_t'(1);
        if (v > hi)
            return hi;
        if (v < lo)
            return lo;
        return v;
    endfunction

    function automatic logic [127:0] isqrt_floor(input logic [255:0] v);
        logic [127:0] r;
        logic [127:0] t;
        logic [255:0] sq;
        r = '0;
        for (int i = 127; i >= 0; i--)
        begin
            t = r | (128'd1 << i);
            sq = {128'd0, t} * {128'd0, t};
            if (sq <= v)
                r = t;
        end
        return r;
    endfunction

    function automatic fit_result_t predict_fit();
        fit_result_t res;
        wide_t bw, bx, by, bxx, byy, bxy, dx, dy, nxy, slope_w, icpt_w, corr_w, root;
        res = '{default: '0};
        res.wt = sum_w;
        res.st = wlra_pkg::STAT_OK;
        if (sum_w == 0)
        begin
            res.st = wlra_pkg::STAT_ZERO_W;
            return res;
        end
        bw = wide_t'(sum_w);
        bx = wide_t'(sum_x);
        by = wide_t'(sum_y);
        bxx = wide_t'(sum_xx);
        byy = wide_t'(sum_yy);
        bxy = wide_t'(sum_xy);
        res.mx = 32'(clamp_signed((bx <<< wlra_pkg::FRAC_BITS_DEF) / bw, 32));
        res.my = 32'(clamp_signed((by <<< wlra_pkg::FRAC_BITS_DEF) / bw, 32));
        res.cxx = 64'(bxx - (bx * bx) / bw);
        res.cyy = 64'(byy - (by * by) / bw);
        res.cxy = 64'(bxy - (bx * by) / bw);
        dx = bw * bxx - bx * bx;
        dy = bw * byy - by * by;
        nxy = bw * bxy - bx * by;
        if (dx <= 0)
        begin
            res.st = wlra_pkg::STAT_ZERO_DX;
            return res;
        end
        slope_w = clamp_signed((nxy <<< wlra_pkg::FRAC_BITS_DEF) / dx, 48);
        icpt_w = clamp_signed(((by <<< wlra_pkg::FRAC_BITS_DEF) - slope_w * bx) / bw, 48);
        res.slp = 48'(slope_w);
        res.icp = 48'(icpt_w);
        if (dy <= 0)
        begin
            res.st = wlra_pkg::STAT_ZERO_DY;
            return res;
        end
        root = {128'd0, isqrt_floor(dx * dy)};
        corr_w = clamp_signed((nxy <<< wlra_pkg::FRAC_BITS_DEF) / root, 18);
        res.cor = 18'(corr_w);
        return res;
    endfunction

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v)
        begin
            fail_count++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        longint xs, ys, w, wx, wy, pxx, pyy, pxy;
        fit_result_t exp_r;
        if (!rst_n)
        begin
            sum_w <= '0;
            sum_x <= '0;
            sum_y <= '0;
            sum_xx <= '0;
            sum_yy <= '0;
            sum_xy <= '0;
            fit_queue.delete();
            fail_count = 0;
            results_checked <= 0;
            results_pending <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (fit_queue.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected result beat, status %0d", $time, status);
                end
                else
                begin
                    exp_r = fit_queue.pop_front();
                    check_field("weight_total", 64'(exp_r.wt), 64'($unsigned(weight_total)));
                    check_field("mean_x", 64'(exp_r.mx), 64'($unsigned(mean_x)));
                    check_field("mean_y", 64'(exp_r.my), 64'($unsigned(mean_y)));
                    check_field("centered_sq_x", exp_r.cxx, $unsigned(centered_sq_x));
                    check_field("centered_sq_y", exp_r.cyy, $unsigned(centered_sq_y));
                    check_field("centered_xy", exp_r.cxy, $unsigned(centered_xy));
                    check_field("slope", 64'(exp_r.slp), 64'($unsigned(slope)));
                    check_field("intercept", 64'(exp_r.icp), 64'($unsigned(intercept)));
                    check_field("correlation", 64'(exp_r.cor), 64'($unsigned(correlation)));
                    check_field("status", 64'(exp_r.st), 64'(status));
                    results_checked <= results_checked + 1;
                end
            end
            if (in_valid && in_ready)
            begin
                case (func)
                    wlra_pkg::FUNC_ADD, wlra_pkg::FUNC_REMOVE:
                    begin
                        xs = longint'(x_value);
                        ys = longint'(y_value);
                        w = longint'(weight);
                        wx = xs * w;
                        wy = ys * w;
                        pxx = wx * xs;
                        pyy = wy * ys;
                        pxy = wx * ys;
                        if (func == wlra_pkg::FUNC_REMOVE)
                        begin
                            w = -w;
                            wx = -wx;
                            wy = -wy;
                            pxx = -pxx;
                            pyy = -pyy;
                            pxy = -pxy;
                        end
                        sum_w <= sum_w + w[31:0];
                        sum_x <= sum_x + wx[47:0];
                        sum_y <= sum_y + wy[47:0];
                        sum_xx <= sum_xx + pxx;
                        sum_yy <= sum_yy + pyy;
                        sum_xy <= sum_xy + pxy;
                    end
                    wlra_pkg::FUNC_CLEAR:
                    begin
                        sum_w <= '0;
                        sum_x <= '0;
                        sum_y <= '0;
                        sum_xx <= '0;
                        sum_yy <= '0;
                        sum_xy <= '0;
                    end
                    default:
                        fit_queue.push_back(predict_fit());
                endcase
            end
            results_pending <= fit_queue.size();
        end
    end

endmodule

// ----- dv/tb_weighted_linear_regression_accumulator_unit.sv -----
// Testbench top for the weighted regression accumulator: clock, reset, beat
// stimulus with idle/stall phases, watchdog and verdict.
// Depends on wlra_pkg, the block and wlra_scoreboard.
`timescale 1ns / 1ps

module tb_weighted_linear_regression_accumulator_unit;

    localparam int TOTAL_BEATS = 1050;
    localparam int IDLE_LIMIT  = 40000;
    localparam int HOLD_CYCLES = 8000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [1:0]         func = wlra_pkg::FUNC_ADD;
    logic signed [15:0] x_value = '0;
    logic signed [15:0] y_value = '0;
    logic [7:0]         weight = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [31:0] weight_total;
    logic signed [31:0] mean_x;
    logic signed [31:0] mean_y;
    logic signed [63:0] centered_sq_x;
    logic signed [63:0] centered_sq_y;
    logic signed [63:0] centered_xy;
    logic signed [47:0] slope;
    logic signed [47:0] intercept;
    logic signed [17:0] correlation;
    logic [1:0]         status;

    int fail_count;
    int results_checked;
    int results_pending;

    int idle_pct = 0;
    int stall_pct = 0;
    int hold_token = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int quiet_cycles = 0;
    int beats = 0;
    int func_beats[4] = '{0, 0, 0, 0};
    int px[$];
    int py[$];
    int pw[$];

    weighted_linear_regression_accumulator_unit uut (.*);

    wlra_scoreboard checker_i (.*);

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (hold_token != hold_seen)
        begin
            hold_seen <= hold_token;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= IDLE_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    task automatic send_beat(input logic [1:0] f, input int x, input int y, input int w);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= f;
        x_value <= x[15:0];
        y_value <= y[15:0];
        weight <= w[7:0];
        do
            @(negedge clk);
        while (!in_ready);
        @(posedge clk);
        beats++;
        func_beats[f]++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_pending != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int slope_k, offset, npts, mode, x, y, w, k, sel;
        bit held, paused;
        held = 0;
        paused = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, empty sums, flat x, flat y, negative weight sum, saturation
        send_beat(wlra_pkg::FUNC_QUERY, 0, 0, 0);
        send_beat(wlra_pkg::FUNC_ADD, -32768, -32768, 255);
        send_beat(wlra_pkg::FUNC_ADD, 32767, 32767, 255);
        send_beat(wlra_pkg::FUNC_ADD, 100, -200, 0);
        send_beat(wlra_pkg::FUNC_QUERY, 0, 0, 0);
        send_beat(wlra_pkg::FUNC_ADD, 0, 32767, 1);
        send_beat(wlra_pkg::FUNC_QUERY, 0, 0, 0);
        send_beat(wlra_pkg::FUNC_REMOVE, 0, 32767, 1);
        send_beat(wlra_pkg::FUNC_QUERY, 0, 0, 0);
        send_beat(wlra_pkg::FUNC_CLEAR, 0, 0, 0);
        send_beat(wlra_pkg::FUNC_ADD, 5, 1, 1);
        send_beat(wlra_pkg::FUNC_ADD, 5, 9, 3);
        send_beat(wlra_pkg::FUNC_QUERY, 0, 0, 0);
        send_beat(wlra_pkg::FUNC_CLEAR, 0, 0, 0);
        send_beat(wlra_pkg::FUNC_ADD, 1, 7, 2);
        send_beat(wlra_pkg::FUNC_ADD, 9, 7, 1);
        send_beat(wlra_pkg::FUNC_QUERY, 0, 0, 0);
        send_beat(wlra_pkg::FUNC_CLEAR, 0, 0, 0);
        send_beat(wlra_pkg::FUNC_REMOVE, 3, 4, 2);
        send_beat(wlra_pkg::FUNC_REMOVE, -7, 11, 5);
        send_beat(wlra_pkg::FUNC_QUERY, 0, 0, 0);
        send_beat(wlra_pkg::FUNC_CLEAR, 0, 0, 0);
        send_beat(wlra_pkg::FUNC_ADD, 32767, -32768, 255);
        send_beat(wlra_pkg::FUNC_REMOVE, -32768, 32767, 254);
        send_beat(wlra_pkg::FUNC_QUERY, 0, 0, 0);

        while (beats < TOTAL_BEATS)
        begin
            case ((beats / 130) % 4)
                0: begin idle_pct = 0;  stall_pct <= 0;  end
                1: begin idle_pct = 78; stall_pct <= 0;  end
                2: begin idle_pct = 0;  stall_pct <= 78; end
                default: begin idle_pct = 32; stall_pct <= 32; end
            endcase
            if (!held && beats > 450)
            begin
                held = 1;
                hold_token <= hold_token + 1;
                for (k = 0; k < 4; k++)
                begin
                    send_beat(wlra_pkg::FUNC_ADD, $urandom_range(0, 4000) - 2000,
                              $urandom_range(0, 4000) - 2000, $urandom_range(1, 9));
                    send_beat(wlra_pkg::FUNC_QUERY, 0, 0, 0);
                end
            end
            if (!paused && beats > 750)
            begin
                paused = 1;
                drain_results();
            end
            sel = $urandom_range(99);
            if (sel < 10)
            begin
                send_beat(2'($urandom_range(3)), $urandom, $urandom, $urandom_range(255));
                continue;
            end
            if (sel < 35)
                send_beat(wlra_pkg::FUNC_CLEAR, $urandom, $urandom, $urandom_range(255));
            px.delete();
            py.delete();
            pw.delete();
            slope_k = $urandom_range(0, 8) - 4;
            offset = $urandom_range(0, 2000) - 1000;
            npts = $urandom_range(2, 12);
            mode = $urandom_range(9);
            for (k = 0; k < npts; k++)
            begin
                if (mode == 0)
                    x = 1234;
                else if (mode < 3)
                    x = $urandom_range(0, 65535) - 32768;
                else
                    x = $urandom_range(0, 2000) - 1000;
                if (mode == 1)
                    y = -4321;
                else if (mode == 2)
                    y = $urandom_range(0, 65535) - 32768;
                else
                    y = slope_k * x + offset + $urandom_range(0, 400) - 200;
                if (y > 32767)
                    y = 32767;
                if (y < -32768)
                    y = -32768;
                if ($urandom_range(99) < 5)
                    w = 0;
                else if ($urandom_range(99) < 20)
                    w = 255;
                else
                    w = $urandom_range(1, 20);
                send_beat(wlra_pkg::FUNC_ADD, x, y, w);
                px.push_back(x);
                py.push_back(y);
                pw.push_back(w);
                if (px.size() > 2 && $urandom_range(99) < 15)
                begin
                    sel = $urandom_range(px.size() - 1);
                    send_beat(wlra_pkg::FUNC_REMOVE, px[sel], py[sel], pw[sel]);
                    px.delete(sel);
                    py.delete(sel);
                    pw.delete(sel);
                end
                if ($urandom_range(99) < 8)
                    send_beat(wlra_pkg::FUNC_QUERY, $urandom, $urandom, $urandom_range(255));
            end
            send_beat(wlra_pkg::FUNC_QUERY, $urandom, $urandom, $urandom_range(255));
        end
        drain_results();
        repeat (100) @(posedge clk);

        $display("Run: %0d beats (add %0d, remove %0d, clear %0d, query %0d)",
                 beats, func_beats[wlra_pkg::FUNC_ADD], func_beats[wlra_pkg::FUNC_REMOVE],
                 func_beats[wlra_pkg::FUNC_CLEAR], func_beats[wlra_pkg::FUNC_QUERY]);
        $display("Checked %0d fit results, %0d failures", results_checked, fail_count);
        if (fail_count == 0 && results_pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
